### rtl/core/iir_df_pkg.sv
package iir_df_pkg;

  // Taps: number of coefficients per side (2 or 3)
  localparam int TAPS = 3;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int FRAC_W   = 14;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  // five products summed: three guard bits
  localparam int ACC_W    = PROD_W + 3;
  localparam int HIST_D   = 2;
  localparam int CNT_W    = 2;

  // Result queue: holds a full start-up burst plus one steady result
  localparam int FIFO_D   = 4;
  localparam int FIFO_AW  = $clog2(FIFO_D);
  localparam int FIFO_CW  = $clog2(FIFO_D + 1);

  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4
  } cfg_reg_t;

endpackage

### rtl/core/iir_df_mac.sv
module iir_df_mac import iir_df_pkg::*; (
  input  sample_t                  x,
  input  coef_set_t                coef,
  input  sample_t [HIST_D-1:0]     x_hist,
  input  sample_t [HIST_D-1:0]     y_hist,
  output sample_t                  y
);

  localparam int Q_W = ACC_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [Q_W-1:0]   Q_MAX    = Q_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [Q_W-1:0]   Q_MIN    = Q_W'(-(2 ** (SAMPLE_W - 1)));

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Q_W-1:0]    q;

  assign p_b0 = $signed(coef.b0) * $signed(x);
  assign p_b1 = $signed(coef.b1) * $signed(x_hist[0]);
  assign p_b2 = $signed(coef.b2) * $signed(x_hist[1]);
  assign p_a1 = $signed(coef.a1) * $signed(y_hist[0]);
  assign p_a2 = $signed(coef.a2) * $signed(y_hist[1]);

  always_comb begin
    acc = ACC_W'(p_b0) + ACC_W'(p_b1) - ACC_W'(p_a1);
    if (TAPS > 2) begin
      acc = acc + ACC_W'(p_b2) - ACC_W'(p_a2);
    end
  end

  // round half up, then floor shift out the Q14 fraction
  assign acc_rnd = acc + RND_HALF;
  assign q       = $signed(acc_rnd[ACC_W-1:FRAC_W]);

  always_comb begin
    if (q > Q_MAX) begin
      y = sample_t'(Q_MAX[SAMPLE_W-1:0]);
    end else if (q < Q_MIN) begin
      y = sample_t'(Q_MIN[SAMPLE_W-1:0]);
    end else begin
      y = sample_t'(q[SAMPLE_W-1:0]);
    end
  end

endmodule

### rtl/core/iir_filter_direct_form.sv
// Direct-form-1 IIR filter (biquad when TAPS is 3) on signed 16-bit samples,
// Q3.14 coefficients with a0 already normalized out. Each input transaction is
// captured in an input register; from it five parallel 16x18 multipliers,
// the sum, round-half-up and 16-bit saturation run in one pass and the
// results go into a 4-entry result queue that drives the out_ port. A
// sample waits in the input register until the queue has room for all of
// its results; out_valid is raised from the registered queue count. The block
// takes one sample per cycle as long as out_ready stays high; the rate is set
// by the combinational multiply-accumulate, whose output feeds back into the
// output history for the next sample. The first TAPS-1 samples are stored
// only (no result). Sample TAPS-1 produces TAPS results: TAPS-1 raw copies of
// itself (last_of_run = 0) followed by the first filtered value
// (last_of_run = 1). Every later sample produces one filtered value with
// last_of_run = 1. Coefficients are written on the cfg_ port (always ready),
// index 0..4 = b0, b1, b2, a1, a2; other indexes are ignored. Write them only
// while the filter is idle.
module iir_filter_direct_form import iir_df_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample_in,
  // filtered output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample_out,
  output logic                  out_last_of_run,
  // coefficient writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_data
);

  // coefficient registers
  coef_set_t            coef_r;

  // input register stage
  logic                 s1_valid_r, s1_valid_nxt;
  sample_t              s1_x_r;

  // filter state
  sample_t [HIST_D-1:0] x_hist_r;
  sample_t [HIST_D-1:0] y_hist_r;
  sample_t [HIST_D-1:0] y_hist_eff;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // result queue
  result_t              fifo_r [FIFO_D];
  logic [FIFO_AW-1:0]   wp_r;
  logic [FIFO_AW-1:0]   rp_r;
  logic [FIFO_CW-1:0]   fcnt_r, fcnt_nxt;
  logic [FIFO_CW-1:0]   free;
  logic [FIFO_CW-1:0]   need;
  logic [FIFO_CW-1:0]   push_n;
  result_t              push_e [TAPS];

  logic                 filling;     // still collecting the initial samples
  logic                 run_start;   // sample that starts the output stream
  logic                 s1_go;
  logic                 in_fire;
  logic                 pop;
  sample_t              y_new;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= coef_t'(1 << FRAC_W);
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_B0: coef_r.b0 <= cfg_data;
        REG_COEF_B1: coef_r.b1 <= cfg_data;
        REG_COEF_B2: coef_r.b2 <= cfg_data;
        REG_COEF_A1: coef_r.a1 <= cfg_data;
        REG_COEF_A2: coef_r.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage control ----
  assign filling   = (cnt_r < CNT_W'(TAPS - 1));
  assign run_start = (cnt_r == CNT_W'(TAPS - 1));

  // results this sample pushes: none while filling, a full burst at run start
  always_comb begin
    if (filling) begin
      need = '0;
    end else if (run_start) begin
      need = FIFO_CW'(TAPS);
    end else begin
      need = FIFO_CW'(1);
    end
  end

  assign free     = FIFO_CW'(FIFO_D) - fcnt_r;
  assign s1_go    = s1_valid_r && (need <= free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r <= in_sample_in;
    end
  end

  // ---- filter datapath ----
  // at run start the output history is seeded with the current sample
  assign y_hist_eff = run_start ? {HIST_D{s1_x_r}} : y_hist_r;

  iir_df_mac u_mac (
    .x      (s1_x_r),
    .coef   (coef_r),
    .x_hist (x_hist_r),
    .y_hist (y_hist_eff),
    .y      (y_new)
  );

  assign cnt_nxt = (s1_go && (filling || run_start)) ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      x_hist_r <= '0;
      y_hist_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_go) begin
        x_hist_r[1] <= x_hist_r[0];
        x_hist_r[0] <= s1_x_r;
        if (!filling) begin
          y_hist_r[1] <= y_hist_eff[0];
          y_hist_r[0] <= y_new;
        end
      end
    end
  end

  // ---- result queue ----
  // burst order: TAPS-1 raw copies, then the filtered value
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      if (run_start && (j < TAPS - 1)) begin
        push_e[j] = '{sample: s1_x_r, last: 1'b0};
      end else if (run_start) begin
        push_e[j] = '{sample: y_new, last: 1'b1};
      end else begin
        push_e[j] = '{sample: y_new, last: 1'b1};
      end
    end
  end

  assign push_n   = s1_go ? need : '0;
  assign pop      = out_valid && out_ready;
  assign fcnt_nxt = fcnt_r + push_n - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
    end else begin
      wp_r   <= wp_r + push_n[FIFO_AW-1:0];
      rp_r   <= rp_r + FIFO_AW'(pop);
      fcnt_r <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < TAPS; j++) begin
      if (FIFO_CW'(j) < push_n) begin
        fifo_r[wp_r + FIFO_AW'(j)] <= push_e[j];
      end
    end
  end

  assign out_valid       = (fcnt_r != '0);
  assign out_sample_out  = fifo_r[rp_r].sample;
  assign out_last_of_run = fifo_r[rp_r].last;

endmodule

### rtl/core/iir_df_checker.sv
module iir_df_checker import iir_df_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_sample_out,
  input logic                out_last_of_run
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a start-up copy is followed at once by the next result of the burst,
  // which is either another copy of the same sample or the filtered value
  a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=>
      out_valid && (out_last_of_run || (out_sample_out == $past(out_sample_out))))
    else $error("start-up burst broken");

  // draining the output always leaves room for a steady-state sample
  a_throughput: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_ready) |-> in_ready)
    else $error("input stalled although output was drained");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_sample_out) && $stable(out_last_of_run))
    else $error("output transaction changed while stalled");

endmodule

bind iir_filter_direct_form iir_df_checker u_iir_df_checker (.*);

### tb/tb.sv
module tb;
  import iir_df_pkg::*;

  localparam int LATENCY         = 1;
  localparam int SETTLE_CYCLES   = LATENCY + 4;
  // The longest legal quiet stretch is set by the long receiver hold.
  localparam int WATCHDOG_LIMIT  = 400;
  localparam int LONG_HOLD       = 40;
  localparam int HOLD_AFTER      = 60;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 40;

  localparam logic [COEF_W-1:0]   COEF_MAX   = 18'h1FFFF;
  localparam logic [COEF_W-1:0]   COEF_MIN   = 18'h20000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

  // Shadow copy of the filter: coefficients, histories and start-up count.
  // Every input transaction is run through it; the values it yields wait in
  // outputs_due until the block hands out the matching result.
  class iir_shadow;
    longint  coef_ff[3];
    longint  coef_fb[3];
    longint  x_hist[2];
    longint  y_hist[2];
    int      primed;
    result_t outputs_due[$];
    int      errors;

    function new();
      coef_ff = '{16384, 0, 0};
      coef_fb = '{0, 0, 0};
      x_hist  = '{0, 0};
      y_hist  = '{0, 0};
      primed  = 0;
      errors  = 0;
    endfunction

    function void add_due(result_t r);
      outputs_due.insert(outputs_due.size(), r);
    endfunction

    function void take_config(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      coef_t c;
      c = data;
      case (idx)
        REG_COEF_B0: coef_ff[0] = longint'(c);
        REG_COEF_B1: coef_ff[1] = longint'(c);
        REG_COEF_B2: coef_ff[2] = longint'(c);
        REG_COEF_A1: coef_fb[1] = longint'(c);
        REG_COEF_A2: coef_fb[2] = longint'(c);
        default: ;  // unknown index: no effect
      endcase
    endfunction

    // Q14 sum -> round half up -> saturate to 16 bits
    function sample_t filter_next(longint xs);
      longint acc;
      longint q;
      acc = coef_ff[0] * xs;
      for (int k = 1; k < TAPS; k++) begin
        acc += coef_ff[k] * x_hist[k-1] - coef_fb[k] * y_hist[k-1];
      end
      q = (acc + 8192) >>> FRAC_W;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return sample_t'(q);
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
      sample_t x;
      sample_t y;
      longint  xs;
      result_t r;
      x  = raw;
      xs = longint'(x);
      if (primed < TAPS - 1) begin
        // start-up: store only
        x_hist[1] = x_hist[0];
        x_hist[0] = xs;
        primed++;
        return;
      end
      if (primed == TAPS - 1) begin
        // raw copies seed the output history
        for (int k = 0; k < TAPS - 1; k++) begin
          y_hist[k] = xs;
          r.sample  = x;
          r.last    = 1'b0;
          add_due(r);
        end
        primed = TAPS;
      end
      y = filter_next(xs);
      x_hist[1] = x_hist[0];
      x_hist[0] = xs;
      y_hist[1] = y_hist[0];
      y_hist[0] = longint'(y);
      r.sample  = y;
      r.last    = 1'b1;
      add_due(r);
    endfunction

    function void match_output(logic [SAMPLE_W-1:0] s, logic l);
      result_t r;
      if (outputs_due.size() == 0) begin
        $error("unexpected result: sample_out %0d last_of_run %0b", $signed(s), l);
        errors++;
        return;
      end
      r = outputs_due.pop_front();
      if (s !== r.sample) begin
        $error("sample_out: expected %0d, actual %0d", r.sample, $signed(s));
        errors++;
      end
      if (l !== r.last) begin
        $error("last_of_run: expected %0b, actual %0b", r.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [SAMPLE_W-1:0]  out_sample_out;
  logic                 out_last_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // idle_on: random bursts of idling on both sides; cleared for the last phase
  bit        idle_on;
  int        quiet_cycles;
  iir_shadow shadow = new();

  always #1 clk = ~clk;

  iir_filter_direct_form i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Monitor: pre-edge values are sampled here, same as the block sees them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow.take_config(cfg_index, cfg_data);
      if (in_valid && in_ready) shadow.take_sample(in_sample_in);
      if (out_valid && out_ready) shadow.match_output(out_sample_out, out_last_of_run);
    end
  end

  // Watchdog: cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls while idle_on, plus one long hold
  // once enough results have gone by. The hold is timed here, so the sender
  // keeps pushing and the result queue backs up into in_ready.
  initial begin
    int stall_left;
    int seen;
    bit held;
    stall_left = 0;
    seen       = 0;
    held       = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) seen++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!held && seen >= HOLD_AFTER) begin
        held       = 1;
        stall_left = LONG_HOLD - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one sample, optionally after a short gap; returns at the accepting edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Caller lowers cfg_valid after a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted result, then cover the pipeline
  // in case the last sample was a start-up one with no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3:    return SAMPLE_W'($urandom_range(0, 511) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // wide: anywhere in Q3.14; otherwise within +-0.5 so the filter mostly settles
  function automatic logic [COEF_W-1:0] pick_coef(bit wide);
    if (wide) return COEF_W'($urandom());
    return COEF_W'($urandom_range(0, 16383) - 8192);
  endfunction

  initial begin
    bit wide;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_on      = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients (pass-through). First TAPS-1 samples only fill the
    // history; the next gives the raw start-up copies plus one filtered value.
    send_sample(16'sd12345);
    send_sample(16'hFFFF);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(16'd1);
    send_sample(16'hFFFE);
    settle();

    // All coefficients at the positive extreme: sums overflow both ways.
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    settle();

    // Negative extreme, then writes to unused indexes, which must change nothing.
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    for (int i = int'(REG_COEF_A2) + 1; i < 2**CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), (i % 2 == 0) ? COEF_MAX : COEF_W'($urandom()));
    end
    cfg_valid <= 1'b0;
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'd1);
    send_sample(SAMPLE_MIN);
    send_sample(16'hFFFF);
    send_sample(SAMPLE_MAX);
    settle();

    // Random phases, alternating moderate and full-range coefficient sets.
    // The last phase runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wide = ph % 2;
      if (ph == RANDOM_PHASES - 1) idle_on = 0;
      load_coefs(pick_coef(wide), pick_coef(wide), pick_coef(wide),
                 pick_coef(wide), pick_coef(wide));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(pick_sample());
      end
      settle();
    end

    if (shadow.errors == 0 && shadow.outputs_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
